/* hdl/acpsq_pkg.sv */
// Package: widths, polynomial coefficients and the Q24 product rounding used by the unit.
package acpsq_pkg;

   localparam int FRAC_BITS = 24;
   localparam int OP_W      = 27;
   localparam int PROD_W    = 2 * OP_W;
   localparam int SQ_N      = 25;
   localparam int X_W       = 16;
   localparam int Y_W       = 17;

   localparam logic [X_W:0] ONE_Q14   = 17'd16384;
   localparam logic [X_W:0] SPLIT_Q14 = 17'd9728;

   localparam logic signed [OP_W-1:0] ONE_Q24  = 27'sd16777216;
   localparam logic signed [OP_W-1:0] HALF_Q24 = 27'sd8388608;

   // Near |x| = 1, constant term first
   localparam logic signed [OP_W-1:0] P1_C0 = -27'sd3399680;
   localparam logic signed [OP_W-1:0] P1_C1 = 27'sd563200;
   localparam logic signed [OP_W-1:0] P1_C2 = -27'sd182016;
   // Near x = 0
   localparam logic signed [OP_W-1:0] P2_C0 = -27'sd5341184;
   localparam logic signed [OP_W-1:0] P2_C1 = -27'sd860672;
   localparam logic signed [OP_W-1:0] P2_C2 = -27'sd584192;

   // Round a Q48 product to Q24, ties away from zero
   function automatic logic signed [OP_W-1:0] rnd_q24(input logic signed [PROD_W-1:0] p);
      logic [PROD_W-1:0] s;
      s = p + 54'd8388608 - {53'd0, p[PROD_W-1]};
      return $signed(s[FRAC_BITS+OP_W-1:FRAC_BITS]);
   endfunction

endpackage

/* hdl/acospi_poly_sqrt_unit_top.sv */
// Top level: pipelined acos(x)/pi by polynomial and square root; one transaction per cycle unless stalled.
//
//   channel | ports                            | direction | payload
//   --------+----------------------------------+-----------+----------------------------
//   request | req_valid, req_stall, req_x_value| in        | x, signed Q1.14
//   response| rsp_valid, rsp_stall,            | out       | acos(x)/pi, unsigned Q1.16
//           | rsp_acospi_value                 |           |
//
// One transaction enters per cycle unless the output is stalled. Five stages serve range
// reduction and the three Horner products, 25 stages the bit-serial square root (one root
// bit each), then the output register. Reset clears the valid bits only. A response stall
// with rsp_valid high freezes the whole pipeline and is passed back as req_stall at once.
module acospi_poly_sqrt_unit_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [15:0]          req_x_value,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [16:0]                 rsp_acospi_value
);
   import acpsq_pkg::*;

   // global advance: every stage moves together unless the output is held
   logic en;
   assign en        = !rsp_valid || !rsp_stall;
   assign req_stall = !en;

   // ---------------- stage 0: magnitude, clamp, range select
   logic                   s0_vld_ff, s0_neg_ff, s0_sel_ff;
   logic [SQ_N-1:0]        s0_a_ff;
   logic [X_W:0]           mag_raw, mag_in;
   logic                   s0_neg_in, s0_sel_in;
   logic [SQ_N-1:0]        s0_a_in;

   always_comb begin
      s0_neg_in = req_x_value[X_W-1];
      mag_raw   = s0_neg_in ? (17'd0 - {req_x_value[X_W-1], req_x_value})
                            : {1'b0, req_x_value};
      mag_in    = (mag_raw > ONE_Q14) ? ONE_Q14 : mag_raw;
      s0_sel_in = mag_in > SPLIT_Q14;
      s0_a_in   = {mag_in[14:0], 10'd0};
   end

   // ---------------- stage 1: a*a for the central range, t = a - 1 for the outer
   logic                   s1_vld_ff, s1_neg_ff, s1_sel_ff;
   logic signed [OP_W-1:0] s1_u_ff, s1_w_ff;
   logic signed [OP_W-1:0] a_s, t_s, s1_u_in, s1_w_in;
   logic signed [PROD_W-1:0] prod1;

   always_comb begin
      a_s     = $signed({2'b00, s0_a_ff});
      t_s     = a_s - ONE_Q24;
      prod1   = a_s * a_s;
      s1_u_in = s0_sel_ff ? t_s : rnd_q24(prod1);
      s1_w_in = s0_sel_ff ? t_s : a_s;
   end

   // ---------------- stage 2: first Horner step
   logic                   s2_vld_ff, s2_neg_ff, s2_sel_ff;
   logic signed [OP_W-1:0] s2_u_ff, s2_w_ff, s2_acc_ff;
   logic signed [PROD_W-1:0] prod2;
   logic signed [OP_W-1:0] s2_acc_in;

   always_comb begin
      prod2     = s1_u_ff * (s1_sel_ff ? P1_C2 : P2_C2);
      s2_acc_in = (s1_sel_ff ? P1_C1 : P2_C1) + rnd_q24(prod2);
   end

   // ---------------- stage 3: second Horner step
   logic                   s3_vld_ff, s3_neg_ff, s3_sel_ff;
   logic signed [OP_W-1:0] s3_w_ff, s3_acc_ff;
   logic signed [PROD_W-1:0] prod3;
   logic signed [OP_W-1:0] s3_acc_in;

   always_comb begin
      prod3     = s2_u_ff * s2_acc_ff;
      s3_acc_in = (s2_sel_ff ? P1_C0 : P2_C0) + rnd_q24(prod3);
   end

   // ---------------- stage 4: final product; central range is finished here
   logic                   s4_vld_ff, s4_neg_ff, s4_sel_ff;
   logic signed [OP_W-1:0] s4_m_ff;
   logic signed [PROD_W-1:0] prod4;
   logic signed [OP_W-1:0] s4_m_in;

   always_comb begin
      prod4   = s3_w_ff * s3_acc_ff;
      s4_m_in = s3_sel_ff ? rnd_q24(prod4) : (HALF_Q24 + rnd_q24(prod4));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_vld_ff <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
      end else if (en) begin
         s0_vld_ff <= req_valid;
         s1_vld_ff <= s0_vld_ff;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_neg_ff <= s0_neg_in;
         s0_sel_ff <= s0_sel_in;
         s0_a_ff   <= s0_a_in;
         s1_neg_ff <= s0_neg_ff;
         s1_sel_ff <= s0_sel_ff;
         s1_u_ff   <= s1_u_in;
         s1_w_ff   <= s1_w_in;
         s2_neg_ff <= s1_neg_ff;
         s2_sel_ff <= s1_sel_ff;
         s2_u_ff   <= s1_u_ff;
         s2_w_ff   <= s1_w_ff;
         s2_acc_ff <= s2_acc_in;
         s3_neg_ff <= s2_neg_ff;
         s3_sel_ff <= s2_sel_ff;
         s3_w_ff   <= s2_w_ff;
         s3_acc_ff <= s3_acc_in;
         s4_neg_ff <= s3_neg_ff;
         s4_sel_ff <= s3_sel_ff;
         s4_m_ff   <= s4_m_in;
      end
   end

   // ---------------- square root: one result bit per stage, restoring
   // radicand is the clamped product shifted up by the fraction width
   logic [SQ_N-1:0]   sq_v;
   assign sq_v = (s4_sel_ff && !s4_m_ff[OP_W-1]) ? s4_m_ff[SQ_N-1:0] : '0;

   logic                   sq_vld_ff  [SQ_N];
   logic                   sq_neg_ff  [SQ_N];
   logic                   sq_sel_ff  [SQ_N];
   logic signed [OP_W-1:0] sq_r_ff    [SQ_N];
   logic [SQ_N+1:0]        sq_rem_ff  [SQ_N];
   logic [SQ_N-1:0]        sq_root_ff [SQ_N];
   logic [2*SQ_N-1:0]      sq_rad_ff  [SQ_N];

   genvar k;
   generate
      for (k = 0; k < SQ_N; k++) begin : g_sq
         logic                   vld_p, neg_p, sel_p;
         logic signed [OP_W-1:0] r_p;
         logic [SQ_N+1:0]        rem_p, rem_sh, trial, rem_in;
         logic [SQ_N-1:0]        root_p, root_in;
         logic [2*SQ_N-1:0]      rad_p;

         if (k == 0) begin : g_first
            assign vld_p  = s4_vld_ff;
            assign neg_p  = s4_neg_ff;
            assign sel_p  = s4_sel_ff;
            assign r_p    = s4_m_ff;
            assign rem_p  = '0;
            assign root_p = '0;
            assign rad_p  = {1'b0, sq_v, 24'd0};
         end else begin : g_next
            assign vld_p  = sq_vld_ff[k-1];
            assign neg_p  = sq_neg_ff[k-1];
            assign sel_p  = sq_sel_ff[k-1];
            assign r_p    = sq_r_ff[k-1];
            assign rem_p  = sq_rem_ff[k-1];
            assign root_p = sq_root_ff[k-1];
            assign rad_p  = sq_rad_ff[k-1];
         end

         always_comb begin
            rem_sh = {rem_p[SQ_N-1:0], rad_p[2*SQ_N-1:2*SQ_N-2]};
            trial  = {root_p, 2'b01};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_p[SQ_N-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_p[SQ_N-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               sq_vld_ff[k] <= 1'b0;
            end else if (en) begin
               sq_vld_ff[k] <= vld_p;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               sq_neg_ff[k]  <= neg_p;
               sq_sel_ff[k]  <= sel_p;
               sq_r_ff[k]    <= r_p;
               sq_rem_ff[k]  <= rem_in;
               sq_root_ff[k] <= root_in;
               sq_rad_ff[k]  <= {rad_p[2*SQ_N-3:0], 2'b00};
            end
         end
      end
   endgenerate

   // ---------------- output: reflect for negative x, clamp to [0,1], round to Q16
   logic signed [OP_W-1:0] fin_r, fin_val;
   logic [OP_W-1:0]        fin_rnd;
   logic [Y_W-1:0]         y_in;
   logic                   rsp_valid_ff;
   logic [Y_W-1:0]         rsp_value_ff;

   always_comb begin
      fin_r   = sq_sel_ff[SQ_N-1] ? $signed({2'b00, sq_root_ff[SQ_N-1]}) : sq_r_ff[SQ_N-1];
      fin_val = sq_neg_ff[SQ_N-1] ? (ONE_Q24 - fin_r) : fin_r;
      if (fin_val[OP_W-1]) begin
         fin_val = '0;
      end else if (fin_val > ONE_Q24) begin
         fin_val = ONE_Q24;
      end
      fin_rnd = fin_val + 27'd128;
      y_in    = fin_rnd[Y_W+7:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= sq_vld_ff[SQ_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_value_ff <= y_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_acospi_value = rsp_value_ff;

endmodule

/* hdl/acpsq_checker.sv */
// Checker: port-level properties of the unit, bound to the top level.
module acpsq_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic signed [15:0] req_x_value,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic [16:0]       rsp_acospi_value
);

   // hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_acospi_value))
      else $error("stalled response changed");

   // back-pressure exactly while the output is held
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall does not follow output stall");

   // result never above 1.0
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_acospi_value <= 17'd65536)
      else $error("result out of range");

   // a stalled request keeps its argument
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_x_value))
      else $error("stalled request changed");

endmodule

bind acospi_poly_sqrt_unit_top acpsq_checker u_acpsq_checker (.*);

/* sim/testbench.sv */
// Testbench for acospi_poly_sqrt_unit_top: queued driver, clocked monitor, fixed-point predictor.
`timescale 1ns / 1ps

module testbench;
   import acpsq_pkg::*;

   // Q24 coefficients, constant term first
   localparam longint NEAR_ONE_C0  = -3399680;
   localparam longint NEAR_ONE_C1  = 563200;
   localparam longint NEAR_ONE_C2  = -182016;
   localparam longint NEAR_ZERO_C0 = -5341184;
   localparam longint NEAR_ZERO_C1 = -860672;
   localparam longint NEAR_ZERO_C2 = -584192;
   localparam longint Q24_ONE      = 64'sd16777216;
   localparam longint Q24_HALF     = 64'sd8388608;
   localparam longint ARG_SPLIT    = 9728;
   localparam longint ARG_ONE      = 16384;
   localparam int     IDLE_LIMIT   = 20000;
   localparam int     LATENCY      = 31;

   typedef enum int {PH_BUSY_RX, PH_BUSY_TX, PH_FREE} pace_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [15:0] req_x_value = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic [16:0]        rsp_acospi_value;

   logic signed [15:0] pending_args[$];
   logic [16:0]        expected_acospi[$];
   pace_type           pace = PH_BUSY_RX;
   bit                 hold_rx = 1'b0;
   bit                 hold_tx = 1'b0;
   bit                 accepted_in = 1'b0;
   int                 error_count = 0;
   int                 checked_count = 0;
   int                 sent_count = 0;
   int                 idle_cycles = 0;

   acospi_poly_sqrt_unit_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_x_value      (req_x_value),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_acospi_value (rsp_acospi_value)
   );

   always #1 clock = ~clock;

   // Q24 product, rounded to nearest with ties away from zero
   function automatic longint q24_product(longint a, longint b);
      longint p;
      longint m;
      p = a * b;
      m = (p < 0) ? -p : p;
      m = (m + (64'sd1 <<< 23)) >>> 24;
      return (p < 0) ? -m : m;
   endfunction

   function automatic longint horner_q24(longint c0, longint c1, longint c2, longint t);
      longint acc;
      acc = c1 + q24_product(t, c2);
      return c0 + q24_product(t, acc);
   endfunction

   function automatic longint floor_root(longint v);
      longint lo;
      longint hi;
      longint mid;
      lo = 0;
      hi = 64'sd1 <<< 32;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (mid * mid <= v) lo = mid;
         else hi = mid;
      end
      return lo;
   endfunction

   function automatic logic [16:0] predict_acospi(logic signed [15:0] x);
      longint mag;
      longint a;
      longint t;
      longint v;
      longint r;
      longint val;
      mag = (x < 0) ? -longint'(x) : longint'(x);
      if (mag > ARG_ONE) mag = ARG_ONE;
      a = mag <<< 10;
      if (mag > ARG_SPLIT) begin
         t = a - Q24_ONE;
         v = q24_product(t, horner_q24(NEAR_ONE_C0, NEAR_ONE_C1, NEAR_ONE_C2, t));
         if (v < 0) v = 0;
         r = floor_root(v <<< 24);
      end else begin
         r = Q24_HALF + q24_product(a, horner_q24(NEAR_ZERO_C0, NEAR_ZERO_C1, NEAR_ZERO_C2,
                                                 q24_product(a, a)));
      end
      val = (x < 0) ? Q24_ONE - r : r;
      if (val < 0) val = 0;
      if (val > Q24_ONE) val = Q24_ONE;
      return 17'((val + 128) >>> 8);
   endfunction

   // Driver: present the queue head, advance on acceptance
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (!req_valid || accepted_in) begin
            if (pending_args.size() > 0 && !hold_tx &&
                !(pace == PH_BUSY_TX && $urandom_range(99) < 84) &&
                !(pace == PH_BUSY_RX && $urandom_range(99) < 12)) begin
               req_x_value <= pending_args.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Acceptance flag sampled at the rising edge
   always @(posedge clock) begin
      accepted_in <= !reset && req_valid && !req_stall;
      if (!reset && req_valid && !req_stall) begin
         expected_acospi.push_back(predict_acospi(req_x_value));
         sent_count <= sent_count + 1;
      end
   end

   // Receiver pacing, changed at the falling edge
   always @(negedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if (hold_rx) rsp_stall <= 1'b1;
      else if (pace == PH_BUSY_RX) rsp_stall <= ($urandom_range(99) < 84);
      else if (pace == PH_BUSY_TX) rsp_stall <= ($urandom_range(99) < 12);
      else rsp_stall <= 1'b0;
   end

   // Monitor: compare each result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_acospi.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d",
                     $realtime, rsp_acospi_value);
            error_count <= error_count + 1;
         end else begin
            if (rsp_acospi_value !== expected_acospi[0]) begin
               $display("%0t: acospi_value mismatch, expected %0d, actual %0d",
                        $realtime, expected_acospi[0], rsp_acospi_value);
               error_count <= error_count + 1;
            end
            void'(expected_acospi.pop_front());
         end
         checked_count <= checked_count + 1;
      end
   end

   // Watchdog: count cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: %0d cycles without a transaction", idle_cycles);
         $display("** acospi_poly_sqrt_unit_top: FAILED **");
         $finish;
      end
   end

   function automatic logic signed [15:0] random_arg();
      int pick;
      pick = $urandom_range(99);
      if (pick < 70) return 16'($signed($urandom_range(32768)) - 16384);
      if (pick < 80) return 16'($signed($urandom_range(40)) + 9708);
      if (pick < 88) return -16'($signed($urandom_range(40)) + 9708);
      return 16'($urandom);
   endfunction

   task automatic drain_all();
      while (pending_args.size() > 0 || req_valid || expected_acospi.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic signed [15:0] directed[$];
      directed = '{16'sd0, 16'sd16384, -16'sd16384, 16'sd16383, -16'sd16383, 16'sd9728,
                   16'sd9729, -16'sd9728, -16'sd9729, 16'sd1, -16'sd1, 16'sd32767,
                   16'sh8000, 16'sd16385, -16'sd16385, 16'sd8192, -16'sd8192,
                   16'sd12000, -16'sd12000, 16'sd20000, -16'sd20000, 16'sh5555,
                   16'shAAAA, 16'sd4096};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed extremes, split point and out-of-range arguments, then random arguments
      foreach (directed[i]) pending_args.push_back(directed[i]);
      repeat (200) pending_args.push_back(random_arg());
      drain_all();

      // Long receiver hold-off while the sender keeps offering
      hold_rx = 1'b1;
      repeat (100) pending_args.push_back(random_arg());
      for (int n = 0; n < 150; n++) @(posedge clock);
      hold_rx = 1'b0;
      drain_all();

      // Sender pause, then busy sender
      pace = PH_BUSY_TX;
      repeat (200) pending_args.push_back(random_arg());
      hold_tx = 1'b1;
      repeat (40) @(posedge clock);
      hold_tx = 1'b0;
      drain_all();

      pace = PH_FREE;
      repeat (250) pending_args.push_back(random_arg());
      drain_all();
      repeat (LATENCY + 10) @(posedge clock);

      $display("Sent %0d arguments over both signs, the split point and saturation;", sent_count);
      $display("checked %0d results under sender, receiver and no back-pressure.", checked_count);
      if (error_count == 0 && expected_acospi.size() == 0) begin
         $display("** acospi_poly_sqrt_unit_top: PASSED **");
      end else begin
         $display("** acospi_poly_sqrt_unit_top: FAILED **");
      end
      $finish;
   end
endmodule

/* acospi_poly_sqrt_unit_top.f */
hdl/acpsq_pkg.sv
hdl/acospi_poly_sqrt_unit_top.sv
hdl/acpsq_checker.sv
sim/testbench.sv
